// File: hw/rtl/psvb_pkg.sv
// Shared types and constants for the polyphonic sine voice bank.
// Holds the voice cell record, command and pipeline tag structs, the
// operation codes, the sine polynomial constants and the top-octave pitch table.
`timescale 1ns / 1ps
`default_nettype none

package psvb_pkg;

	typedef enum logic [1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_TICK     = 2'd2
	} op_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// One voice as held in a cell of the chain.
	typedef struct packed {
		logic        valid;
		logic [6:0]  note;
		logic [6:0]  vel;
		logic [31:0] phase;
	} voice_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic       rot;
		logic       on;
		logic       off;
		logic [6:0] note;
		logic [6:0] vel;
	} cmd_t;

	// Tag that travels beside a voice through the sine pipeline.
	typedef struct packed {
		logic       live;
		logic       last;
		logic [6:0] vel;
	} tag_t;

	localparam logic [15:0] SIN_A = 16'd51472;
	localparam logic [14:0] SIN_B = 15'd21023;
	localparam logic [11:0] SIN_C = 12'd2320;

	localparam logic [15:0] X_ONE     = 16'h8000;
	localparam logic [15:0] S_MAX     = 16'd32767;

	// Frequencies of notes 120 to 131 in Hz, Q16.16.
	localparam logic [31:0] TOP_OCTAVE_Q16 [12] = '{
		32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
		32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
		32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
	};

endpackage

`default_nettype wire

// File: hw/rtl/psvb_cell.sv
// One cell of the voice chain: holds a single voice and takes its
// neighbor's voice on a shift. Depends on psvb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psvb_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire psvb_pkg::cmd_t  cmd,
	input  wire logic            prev_valid,
	input  wire logic            hit_in,
	input  wire psvb_pkg::voice_t nbr,
	output psvb_pkg::voice_t     cur,
	output logic                 hit_out
);
	import psvb_pkg::*;

	voice_t voice_q;
	logic   match;
	logic   load;
	logic   shift;

	// A note-off hit here or in an older cell moves this cell down.
	assign match   = voice_q.valid && (voice_q.note == cmd.note);
	assign hit_out = hit_in | match;
	assign load    = cmd.on && !voice_q.valid && prev_valid;
	assign shift   = cmd.rot || (cmd.off && hit_out);
	assign cur     = voice_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_q <= '0;
		end else if (shift) begin
			voice_q <= nbr;
		end else if (load) begin
			voice_q.valid <= 1'b1;
			voice_q.note  <= cmd.note;
			voice_q.vel   <= cmd.vel;
			voice_q.phase <= '0;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/psvb_sine.sv
// Five-stage pipelined Q15 sine from a phase angle index, using a
// truncated odd polynomial per quarter wave. Depends on psvb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psvb_sine #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire psvb_pkg::tag_t             tag_in,
	input  wire logic [SINE_TABLE_BITS-1:0] angle,
	output psvb_pkg::tag_t                  tag_out,
	output logic signed [15:0]              sine
);
	import psvb_pkg::*;

	localparam int REST_W = SINE_TABLE_BITS - 2;
	localparam int SHIFT  = 15 - REST_W;

	logic [1:0]        quad;
	logic [REST_W-1:0] rest;
	logic [15:0]       x_raw;
	logic [15:0]       x_in;

	logic [15:0] x_s1, x_s2, x_s3, x_s4;
	logic [15:0] x2_s2, x2_s3;
	logic [11:0] t_s3;
	logic [14:0] u_s4;
	logic signed [15:0] sine_s5;
	logic neg_s1, neg_s2, neg_s3, neg_s4;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic [31:0] sq;
	logic [27:0] tc;
	logic [30:0] ub;
	logic [14:0] b_minus_t;
	logic [15:0] a_minus_u;
	logic [31:0] sa;
	logic [15:0] s_raw;
	logic [15:0] s_lim;

	assign quad  = angle[SINE_TABLE_BITS-1 -: 2];
	assign rest  = angle[REST_W-1:0];
	assign x_raw = 16'(rest) << SHIFT;
	assign x_in  = quad[0] ? (X_ONE - x_raw) : x_raw;

	assign sq        = 32'(x_s1) * 32'(x_s1);
	assign tc        = 28'(x2_s2) * 28'(SIN_C);
	assign b_minus_t = SIN_B - 15'(t_s3);
	assign ub        = 31'(x2_s3) * 31'(b_minus_t);
	assign a_minus_u = SIN_A - 16'(u_s4);
	assign sa        = 32'(x_s4) * 32'(a_minus_u);
	assign s_raw     = sa[30:15];
	assign s_lim     = (s_raw > S_MAX) ? S_MAX : s_raw;

	// Only the valid markers of the tags need a reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_in;
		neg_s1  <= quad[1];
		x2_s2   <= sq[30:15];
		x_s2    <= x_s1;
		neg_s2  <= neg_s1;
		t_s3    <= tc[26:15];
		x2_s3   <= x2_s2;
		x_s3    <= x_s2;
		neg_s3  <= neg_s2;
		u_s4    <= ub[29:15];
		x_s4    <= x_s3;
		neg_s4  <= neg_s3;
		sine_s5 <= neg_s4 ? -$signed(s_lim) : $signed(s_lim);
	end

	assign tag_out = tag_s5;
	assign sine    = sine_s5;

endmodule

`default_nettype wire

// File: hw/rtl/polyphonic_sine_voice_bank.sv
// Top level of the polyphonic sine voice bank: voice cell chain, tick
// sequencer, shared sine pipeline and mixer. Depends on psvb_pkg,
// psvb_cell and psvb_sine.
`timescale 1ns / 1ps
`default_nettype none

// A user issues one item per start pulse while busy is low. Note-on and
// note-off take effect in the accepting cycle and keep busy low, so one can
// follow every cycle. A sample tick raises busy until its result is out: the
// voice chain rotates once through its VOICES cells, feeding one voice per
// cycle into the single shared sine and mix pipeline, which then drains
// through the sine stages, the loudness multiply and the accumulator. The
// next item is therefore taken only once busy has fallen again. The result
// appears for exactly one cycle with done high, and is taken at the edge that
// ends that cycle; it is not held, so the receiver must take it in that cycle.
// Note-on and note-off produce no result.
module polyphonic_sine_voice_bank #(
	parameter int VOICES          = 6,
	parameter int SINE_TABLE_BITS = 10,
	parameter int SAMPLE_RATE     = 48000
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [6:0]  note,
	input  wire logic [6:0]  velocity,
	output logic             done,
	output logic signed [15:0] sample,
	output logic             clipped
);
	import psvb_pkg::*;

	localparam int CNT_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	// Largest possible magnitude of the mix sum plus a sign bit.
	localparam int ACC_W = $clog2(VOICES * 127 * 32767 + 1) + 1;

	// Phase increment for every MIDI note, worked out at elaboration.
	logic [31:0] inc_table [128];
	for (genvar n = 0; n < 128; n++) begin : g_inc
		localparam logic [63:0] NUM =
			((64'(TOP_OCTAVE_Q16[n % 12]) >> (10 - n / 12)) << 16)
			+ 64'(SAMPLE_RATE / 2);
		localparam logic [31:0] INC = 32'(NUM / 64'(SAMPLE_RATE));
		assign inc_table[n] = INC;
	end

	logic   accept;
	cmd_t   cmd;
	voice_t cells [VOICES];
	logic   hit   [VOICES+1];
	voice_t head_next;
	voice_t tail_in;

	state_t st_q, st_d;
	logic [CNT_W-1:0] feed_cnt_q;
	logic feeding;
	logic feed_last;
	logic finish;
	logic tick_start;

	tag_t tag_in;
	tag_t tag_o;
	logic signed [15:0] sine_o;
	tag_t tag_s6;
	logic signed [23:0] prod_s6;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W:0] rnd;
	logic signed [ACC_W:0] q;

	assign accept     = start && !busy;
	assign tick_start = accept && (operation == OP_TICK);

	// Commands reach every cell at once; the cells sort out who acts.
	always_comb begin
		cmd      = '0;
		cmd.rot  = feeding;
		cmd.note = note;
		cmd.vel  = velocity;
		if (accept) begin
			unique case (operation)
				OP_NOTE_ON:  cmd.on  = 1'b1;
				OP_NOTE_OFF: cmd.off = 1'b1;
				default:     ;
			endcase
		end
	end

	// During a tick the head voice wraps to the tail with its phase advanced.
	// On a note-off the freed tail slot fills with an empty voice.
	always_comb begin
		head_next = cells[0];
		if (cells[0].valid) begin
			head_next.phase = cells[0].phase + inc_table[cells[0].note];
		end
		tail_in = feeding ? head_next : '0;
	end

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < VOICES; i++) begin : g_cell
		psvb_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid ((i == 0) ? 1'b1 : cells[(i == 0) ? 0 : i-1].valid),
			.hit_in     (hit[i]),
			.nbr        ((i == VOICES-1) ? tail_in : cells[(i == VOICES-1) ? i : i+1]),
			.cur        (cells[i]),
			.hit_out    (hit[i+1])
		);
	end

	// Tick sequencer: feed the chain, wait for the pipeline, then finish.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (tick_start) st_d = ST_FEED;
			ST_FEED:   if (feed_last) st_d = ST_DRAIN;
			ST_DRAIN:  if (tag_s6.last) st_d = ST_FINISH;
			ST_FINISH: st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		feeding = 1'b0;
		finish  = 1'b0;
		busy    = 1'b1;
		unique case (st_q)
			ST_IDLE:   busy    = 1'b0;
			ST_FEED:   feeding = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: finish  = 1'b1;
			default:   busy    = 1'b0;
		endcase
	end

	assign feed_last = feeding && (feed_cnt_q == CNT_W'(VOICES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			feed_cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (feeding) begin
				feed_cnt_q <= feed_last ? '0 : feed_cnt_q + 1'b1;
			end
		end
	end

	// Empty cells enter the pipeline with zero loudness.
	assign tag_in.live = feeding;
	assign tag_in.last = feed_last;
	assign tag_in.vel  = cells[0].valid ? cells[0].vel : 7'd0;

	psvb_sine #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_sine (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_in),
		.angle   (cells[0].phase[31 -: SINE_TABLE_BITS]),
		.tag_out (tag_o),
		.sine    (sine_o)
	);

	// Loudness multiply, then accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s6 <= '0;
		end else begin
			tag_s6 <= tag_o;
		end
	end

	always_ff @(posedge clk) begin
		prod_s6 <= 24'($signed({1'b0, tag_o.vel})) * 24'(sine_o);
		if (tick_start) begin
			acc_q <= '0;
		end else if (tag_s6.live) begin
			acc_q <= acc_q + ACC_W'(prod_s6);
		end
	end

	// Scale by 1/256 with rounding half up, which is a floor after adding
	// half, then saturate to 16 bits.
	assign rnd = (ACC_W+1)'(acc_q) + (ACC_W+1)'(128);
	assign q   = rnd >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (q > (ACC_W+1)'(32767)) begin
				sample  <= 16'sh7fff;
				clipped <= 1'b1;
			end else if (q < -(ACC_W+1)'(32768)) begin
				sample  <= -16'sh8000;
				clipped <= 1'b1;
			end else begin
				sample  <= q[15:0];
				clipped <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
